### hdl/granule_bitmap_mark_allocated_defines.svh
// assertion macros for the granule bitmap mark-allocated block
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef GRANULE_BITMAP_MARK_ALLOCATED_DEFINES_SVH
`define GRANULE_BITMAP_MARK_ALLOCATED_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define GBMA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GBMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/gbma_pkg.sv
// shared types and constants for the granule bitmap mark-allocated block
// no dependencies
`timescale 1ns / 1ps

package gbma_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_IDX_W = 5;
  localparam logic [31:0] FULL_MASK = 32'hffff_ffff;

  // configuration register indexes (paddr bit 2)
  localparam logic REG_HEAP_START    = 1'b0;
  localparam logic REG_GRANULE_SHIFT = 1'b1;

  localparam logic [4:0] GRANULE_SHIFT_RST = 5'd6;

  // classified request from the front part
  typedef struct packed {
    logic        pass;
    logic [31:0] address;
    logic [31:0] lo_mask;
    logic [31:0] hi_mask;
  } gbma_req_t;

  // one result item
  typedef struct packed {
    logic        ok;
    logic [31:0] address;
  } gbma_res_t;

  // status of the back part
  typedef struct packed {
    logic clearing;
    logic busy;
  } gbma_stat_t;

endpackage

### hdl/gbma_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module gbma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/gbma_fifo.sv
// small flip-flop queue used between the front and back parts and for results
// no dependencies
`timescale 1ns / 1ps

module gbma_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### hdl/gbma_front.sv
// front part: takes requests, computes the granule and run masks, rejects bad ones
// depends on gbma_pkg
`timescale 1ns / 1ps

module gbma_front #(
  parameter int unsigned TABLE_WORDS = 32,
  parameter int unsigned WIDX_W      = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [31:0]              address_i,
  input  logic [5:0]               count_i,
  input  logic [31:0]              heap_start_i,
  input  logic [4:0]               granule_shift_i,
  input  logic                     clearing_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output logic [WIDX_W-1:0]        q_widx_o,
  output gbma_pkg::gbma_req_t      q_req_o
);

  import gbma_pkg::*;

  localparam logic [32:0] GRAN_LIMIT = 33'(TABLE_WORDS * WORD_BITS);
  localparam logic [WIDX_W:0] WORDS_W = (WIDX_W + 1)'(TABLE_WORDS);

  logic        f_valid_q, f_valid_d;
  logic [31:0] f_addr_q;
  logic [5:0]  f_cnt_q;
  logic        accept;

  logic                 below, cnt_bad, over, past_end;
  logic [31:0]          offset, gran, base_mask;
  logic [32:0]          gran_end;
  logic [63:0]          run;
  logic [WIDX_W-1:0]    widx;
  logic [BIT_IDX_W-1:0] bit_idx;

  // input stage handshake
  assign full     = clearing_i || (f_valid_q && q_full_i);
  assign accept   = push && !full;
  assign q_push_o = f_valid_q && !q_full_i;

  always_comb begin
    f_valid_d = f_valid_q;
    if (accept) begin
      f_valid_d = 1'b1;
    end else if (q_push_o) begin
      f_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_addr_q <= address_i;
      f_cnt_q  <= count_i;
    end
  end

  // granule number and range checks
  assign below    = (f_addr_q < heap_start_i);
  assign cnt_bad  = (f_cnt_q == 6'd0) || (f_cnt_q > 6'd32);
  assign offset   = f_addr_q - heap_start_i;
  assign gran     = offset >> granule_shift_i;
  assign gran_end = {1'b0, gran} + 33'(f_cnt_q);
  assign over     = (gran_end > GRAN_LIMIT);
  assign widx     = WIDX_W'(gran >> BIT_IDX_W);
  assign bit_idx  = gran[BIT_IDX_W-1:0];

  // run mask over a two-word window
  assign base_mask = f_cnt_q[5] ? FULL_MASK : ((32'd1 << f_cnt_q[4:0]) - 32'd1);
  assign run       = {32'd0, base_mask} << bit_idx;
  assign past_end  = (run[63:32] != '0) && (({1'b0, widx} + (WIDX_W + 1)'(1)) >= WORDS_W);

  assign q_widx_o        = widx;
  assign q_req_o.pass    = !(below || cnt_bad || over || past_end);
  assign q_req_o.address = f_addr_q;
  assign q_req_o.lo_mask = run[31:0];
  assign q_req_o.hi_mask = run[63:32];

endmodule

### hdl/gbma_back.sv
// back part: bitmap in even/odd word banks, read-check-write of one request
// depends on gbma_pkg and gbma_ram
`timescale 1ns / 1ps

module gbma_back #(
  parameter int unsigned TABLE_WORDS = 32,
  parameter int unsigned WIDX_W      = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_empty_i,
  input  logic [WIDX_W-1:0]        q_widx_i,
  input  gbma_pkg::gbma_req_t      q_req_i,
  output logic                     q_pop_o,
  input  logic                     res_full_i,
  output logic                     res_push_o,
  output gbma_pkg::gbma_res_t      res_o,
  output gbma_pkg::gbma_stat_t     stat_o
);

  import gbma_pkg::*;

  localparam int unsigned BANK_DEPTH = (TABLE_WORDS + 1) / 2;
  localparam int unsigned BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // bank address of the even word in the window
  function automatic logic [BANK_AW-1:0] even_addr(input logic [WIDX_W-1:0] w);
    logic [WIDX_W:0] wp1;
    wp1 = {1'b0, w} + (WIDX_W + 1)'(1);
    return w[0] ? BANK_AW'(wp1 >> 1) : BANK_AW'(w >> 1);
  endfunction

  logic               clr_q, clr_d;
  logic [BANK_AW-1:0] clr_addr_q, clr_addr_d;
  logic               busy_q;
  logic               start;
  logic [WIDX_W-1:0]  ent_widx_q;
  gbma_req_t          ent_req_q;

  logic [BANK_AW-1:0] ev_raddr, od_raddr, ev_addr, od_addr;
  logic [31:0]        ev_mask, od_mask, ev_rdata, od_rdata;
  logic               conflict, success;
  logic               ev_we, od_we;
  logic [BANK_AW-1:0] ev_waddr, od_waddr;
  logic [31:0]        ev_wdata, od_wdata;

  // clearing sweep after reset
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      if (clr_addr_q == BANK_AW'(BANK_DEPTH - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + BANK_AW'(1);
      end
    end
  end

  // start a request when idle and a result slot is free
  assign start   = !clr_q && !busy_q && !q_empty_i && !res_full_i;
  assign q_pop_o = start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      busy_q     <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      busy_q     <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      ent_widx_q <= q_widx_i;
      ent_req_q  <= q_req_i;
    end
  end

  // read addresses from the queue head
  assign ev_raddr = even_addr(q_widx_i);
  assign od_raddr = BANK_AW'(q_widx_i >> 1);

  // window mapping of the request in flight
  assign ev_addr = even_addr(ent_widx_q);
  assign od_addr = BANK_AW'(ent_widx_q >> 1);
  assign ev_mask = ent_widx_q[0] ? ent_req_q.hi_mask : ent_req_q.lo_mask;
  assign od_mask = ent_widx_q[0] ? ent_req_q.lo_mask : ent_req_q.hi_mask;

  // check and mark
  assign conflict = ((ev_rdata & ev_mask) != '0) || ((od_rdata & od_mask) != '0);
  assign success  = ent_req_q.pass && !conflict;

  assign ev_we    = clr_q || (busy_q && success && (ev_mask != '0));
  assign od_we    = clr_q || (busy_q && success && (od_mask != '0));
  assign ev_waddr = clr_q ? clr_addr_q : ev_addr;
  assign od_waddr = clr_q ? clr_addr_q : od_addr;
  assign ev_wdata = clr_q ? '0 : (ev_rdata | ev_mask);
  assign od_wdata = clr_q ? '0 : (od_rdata | od_mask);

  gbma_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BANK_DEPTH)
  ) u_even_bank (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (ev_waddr),
    .wdata_i (ev_wdata),
    .raddr_i (ev_raddr),
    .rdata_o (ev_rdata)
  );

  gbma_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BANK_DEPTH)
  ) u_odd_bank (
    .clk_i   (clk_i),
    .we_i    (od_we),
    .waddr_i (od_waddr),
    .wdata_i (od_wdata),
    .raddr_i (od_raddr),
    .rdata_o (od_rdata)
  );

  // result
  assign res_push_o    = busy_q;
  assign res_o.ok      = success;
  assign res_o.address = success ? ent_req_q.address : '0;

  assign stat_o.clearing = clr_q;
  assign stat_o.busy     = busy_q;

endmodule

### hdl/granule_bitmap_mark_allocated.sv
// top level of the granule bitmap mark-allocated block
// depends on gbma_pkg, gbma_front, gbma_fifo, gbma_back and the assertion header
//
//   channel   direction  handshake             payload
//   request   in         push / full           address_i, count_i
//   result    out        empty / pop           ok_o, result_address_o
//   config    in         psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// in the back part a request goes through a registered bitmap read, then check and write
// the back part starts no new request while one is in flight; results pass through the result queue
// after reset the bitmap banks are swept to zero, full held high
// a two-entry queue parts front and back; a two-entry result queue buffers results against pop stalls
// configuration writes go straight into the registers and are taken at any time
`timescale 1ns / 1ps
`include "granule_bitmap_mark_allocated_defines.svh"

module granule_bitmap_mark_allocated #(
  parameter int unsigned TABLE_WORDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] address_i,
  input  logic [5:0]  count_i,
  output logic        empty,
  input  logic        pop,
  output logic        ok_o,
  output logic [31:0] result_address_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import gbma_pkg::*;

  localparam int unsigned WIDX_W  = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
  localparam int unsigned REQ_W   = WIDX_W + $bits(gbma_req_t);
  localparam int unsigned RES_W   = $bits(gbma_res_t);

  logic [31:0] heap_start_q;
  logic [4:0]  granule_shift_q;
  logic        cfg_write;

  logic              q_push, q_pop, q_full, q_empty;
  logic [WIDX_W-1:0] f_widx, b_widx;
  gbma_req_t         f_req, b_req;
  logic [REQ_W-1:0]  q_rdata;

  logic       res_push, res_full;
  gbma_res_t  res_in, res_out;
  logic [RES_W-1:0] res_rdata;
  gbma_stat_t bstat;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_start_q    <= '0;
      granule_shift_q <= GRANULE_SHIFT_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_HEAP_START:    heap_start_q    <= pwdata;
        REG_GRANULE_SHIFT: granule_shift_q <= pwdata[4:0];
        default:           heap_start_q    <= heap_start_q;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_GRANULE_SHIFT) ? {27'd0, granule_shift_q} : heap_start_q;

  // front part
  gbma_front #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .address_i       (address_i),
    .count_i         (count_i),
    .heap_start_i    (heap_start_q),
    .granule_shift_i (granule_shift_q),
    .clearing_i      (bstat.clearing),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_widx_o        (f_widx),
    .q_req_o         (f_req)
  );

  // request queue between front and back
  gbma_fifo #(
    .WIDTH (REQ_W),
    .DEPTH (2)
  ) u_req_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_widx, f_req}),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign b_widx = q_rdata[REQ_W-1 -: WIDX_W];
  assign b_req  = q_rdata[$bits(gbma_req_t)-1:0];

  // back part
  gbma_back #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_widx_i   (b_widx),
    .q_req_i    (b_req),
    .q_pop_o    (q_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in),
    .stat_o     (bstat)
  );

  // result queue
  gbma_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign res_out          = res_rdata;
  assign ok_o             = res_out.ok;
  assign result_address_o = res_out.address;

  // checks
  `GBMA_ASSERT_SAME(a_clear_holds_full, bstat.clearing, full, "request taken during bitmap clear")
  `GBMA_ASSERT_SAME(a_fail_addr_zero, !empty && !ok_o, result_address_o == 32'd0, "failed transfer carries an address")
  `GBMA_ASSERT_NEXT(a_busy_one_cycle, bstat.busy, !bstat.busy, "back part started on a request still in flight")
  `GBMA_ASSERT_SAME(a_no_work_in_clear, bstat.clearing, !bstat.busy && q_empty, "request in back part during clear")

endmodule

### bench/tb_top.sv
// self-checking bench for granule_bitmap_mark_allocated: queue-style request and result ports
// drives directed and random mark requests, predicts each result from a private bitmap copy
// depends on gbma_pkg (register indexes) and the granule_bitmap_mark_allocated top level
`timescale 1ns / 1ps

module tb_top;

  import gbma_pkg::*;

  localparam int unsigned MAP_WORDS   = 32;
  localparam int unsigned MAP_BITS    = MAP_WORDS * 32;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned TAIL_CYCLES = 16;

  typedef struct packed {
    logic [31:0] address;
    logic [5:0]  count;
  } mark_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
  } mark_res_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        push    = 1'b0;
  logic        full;
  logic [31:0] address_i = '0;
  logic [5:0]  count_i   = '0;
  logic        empty;
  logic        pop     = 1'b0;
  logic        ok_o;
  logic [31:0] result_address_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // private copy of the block state and configuration
  logic [31:0] granule_map [MAP_WORDS];
  logic [31:0] heap_base   = 32'd0;
  logic [4:0]  gran_shift  = GRANULE_SHIFT_RST;

  mark_req_t   req_backlog [$];
  mark_res_t   expected_marks [$];
  mark_req_t   next_req;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;

  granule_bitmap_mark_allocated #(
    .TABLE_WORDS(MAP_WORDS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .address_i        (address_i),
    .count_i          (count_i),
    .empty            (empty),
    .pop              (pop),
    .ok_o             (ok_o),
    .result_address_o (result_address_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predicted outcome of one mark request; sets the covered granules on success
  function automatic mark_res_t mark_granules(input logic [31:0] addr, input logic [5:0] cnt);
    mark_res_t   res;
    logic [31:0] offset;
    logic [63:0] granule;
    logic [63:0] run;
    logic [31:0] lo_bits;
    logic [31:0] hi_bits;
    int unsigned widx;
    res = '0;
    if (addr < heap_base || cnt == 6'd0 || cnt > 6'd32) return res;
    offset  = addr - heap_base;
    granule = 64'(offset >> gran_shift);
    if (granule + 64'(cnt) > 64'(MAP_BITS)) return res;
    widx    = int'(granule >> 5);
    run     = ((64'd1 << cnt) - 64'd1) << granule[4:0];
    lo_bits = run[31:0];
    hi_bits = run[63:32];
    if ((granule_map[widx] & lo_bits) != 32'd0) return res;
    if (hi_bits != 32'd0) begin
      if (widx + 1 >= MAP_WORDS) return res;
      if ((granule_map[widx + 1] & hi_bits) != 32'd0) return res;
      granule_map[widx + 1] = granule_map[widx + 1] | hi_bits;
    end
    granule_map[widx] = granule_map[widx] | lo_bits;
    res.ok      = 1'b1;
    res.address = addr;
    return res;
  endfunction

  // address of granule g under the current heap layout, with a random offset inside it
  function automatic logic [31:0] granule_addr(input int unsigned g);
    logic [31:0] inner_mask;
    inner_mask = (32'd1 << gran_shift) - 32'd1;
    return heap_base + (32'(g) << gran_shift) + ($urandom & inner_mask);
  endfunction

  // random request: mostly well-formed runs, the rest edge and noise cases
  function automatic mark_req_t random_request();
    mark_req_t   r;
    int unsigned kind;
    int unsigned cnt;
    kind = $urandom_range(99);
    cnt  = ($urandom_range(3) == 0) ? $urandom_range(32, 1) : $urandom_range(4, 1);
    r.count   = 6'(cnt);
    r.address = granule_addr($urandom_range(MAP_BITS - cnt));
    if (kind < 10) begin
      // count of zero or above the limit
      r.count = ($urandom_range(1) == 0) ? 6'd0 : 6'($urandom_range(63, 33));
    end else if (kind < 20) begin
      // run crossing the end of the table
      r.address = granule_addr(MAP_BITS - cnt + $urandom_range(40, 1));
    end else if (kind < 30) begin
      // below the heap start, or any address when the heap starts at 0
      r.address = (heap_base == 32'd0) ? $urandom : $urandom_range(heap_base - 32'd1);
    end else if (kind < 40) begin
      r.address = $urandom;
      r.count   = 6'($urandom_range(63));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  // one register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_HEAP_START) heap_base = value;
    else gran_shift = value[4:0];
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || push || expected_marks.size() != 0);
  endtask

  task automatic add_request(input logic [31:0] addr, input logic [5:0] cnt);
    mark_req_t r;
    r.address = addr;
    r.count   = cnt;
    req_backlog.push_back(r);
  endtask

  // one configuration setting with a burst of random requests, then a full drain
  task automatic run_phase(input logic [31:0] heap, input logic [4:0] shift, input int n,
                           input int s_idle, input int r_idle);
    write_reg(REG_HEAP_START, heap);
    write_reg(REG_GRANULE_SHIFT, {27'd0, shift});
    @(negedge clk_i);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (n) req_backlog.push_back(random_request());
    wait_drained();
  endtask

  // request driver: present the next item when the slot is free, with random idle gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) expected_marks.push_back(mark_granules(address_i, count_i));
      if (!push || !full) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req   = req_backlog.pop_front();
          push      <= 1'b1;
          address_i <= next_req.address;
          count_i   <= next_req.count;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_marks.size() == 0) begin
          report_mismatch("unexpected result address", 32'd0, result_address_o);
        end else begin
          if (ok_o !== expected_marks[0].ok)
            report_mismatch("ok", 32'(expected_marks[0].ok), 32'(ok_o));
          if (result_address_o !== expected_marks[0].address)
            report_mismatch("result address", expected_marks[0].address, result_address_o);
          void'(expected_marks.pop_front());
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    foreach (granule_map[w]) granule_map[w] = 32'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed requests under the reset layout (heap at 0, 64-byte granules)
    @(negedge clk_i);
    send_idle_pct = 35;
    recv_idle_pct = 64;
    add_request(32'd0, 6'd0);                  // zero count
    add_request(32'd0, 6'd33);                 // count just above the limit
    add_request(32'd0, 6'd63);
    add_request(32'd0, 6'd1);                  // first granule
    add_request(32'd5, 6'd1);                  // same granule again, already taken
    add_request(32'd32 << 6, 6'd32);           // one whole word
    add_request(32'd69 << 6, 6'd32);           // widest run straddling two words
    add_request(32'd68 << 6, 6'd2);            // low word overlaps
    add_request(32'd161 << 6, 6'd1);
    add_request(32'd158 << 6, 6'd4);           // only the upper word overlaps
    add_request(32'd158 << 6, 6'd3);           // straddle fitting next to it
    add_request(32'd1016 << 6, 6'd8);          // ends exactly at the table end
    add_request(32'd1017 << 6, 6'd8);          // one granule past the end
    add_request(32'd1023 << 6, 6'd1);          // last granule, taken
    add_request((32'd992 << 6) + 32'd63, 6'd24);
    add_request(32'd991 << 6, 6'd2);           // into the last word, taken
    add_request(32'hffff_ffff, 6'd1);          // far past the table
    add_request(32'd101 << 6, 6'd32);
    add_request(32'd1000 << 6, 6'd32);         // widest run past the end
    add_request(32'd200 << 6, 6'd16);
    add_request(32'd200 << 6, 6'd16);
    wait_drained();

    // random requests across several layouts, extremes included
    run_phase(32'h0000_4000, 5'd3,  350, 35, 64);
    run_phase(32'hffff_ffff, 5'd0,  150, 64, 35);
    run_phase(32'h0000_0000, 5'd31, 150, 64, 35);
    run_phase(32'h8000_0000, 5'd12, 350, 64, 35);
    run_phase(32'h0123_4560, 5'd6,  400, 0,  0);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_marks.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
